>>> src/qcs_pkg.sv
// ----------------------------------------------------------------------------
// qcs_pkg
// Shared types and constants of the quadrature count and speed block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qcs_pkg;

  // default parameter values
  localparam int QCS_NUM_WHEELS  = 2;
  localparam int QCS_SPEED_SCALE = 1000;

  localparam int MS_PER_SEC = 1000;
  localparam int CFG_W      = 16;

  localparam logic [CFG_W-1:0] PERIOD_RST = 16'd10;
  localparam logic [CFG_W-1:0] CPR_RST    = 16'd500;

  // register index, taken from paddr[2]
  localparam logic REG_PERIOD = 1'b0;
  localparam logic REG_CPR    = 1'b1;

  typedef enum logic [1:0] {
    MODE_EDGE   = 2'd0,
    MODE_SAMPLE = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_READ   = 2'd3
  } qcs_mode_e;

  typedef struct packed {
    logic edge_upd;
    logic clear_all;
    logic cap_read;
    logic cap_sample;
    logic mul1;
    logic ld1;
    logic sat1;
    logic mul2;
    logic ld2;
    logic sat2;
    logic push;
  } qcs_cmd_t;

  typedef struct packed {
    logic div_done;
  } qcs_sts_t;

endpackage

>>> src/quadrature_count_and_speed_top.sv
// ----------------------------------------------------------------------------
// quadrature_count_and_speed_top
// Two-wheel quadrature counter with speed sampling and APB configuration.
// ----------------------------------------------------------------------------
// Each accepted item is one of four requests. Edge events and clear-all
// change only the wheel counts and give no result. A count read captures the
// count and then pushes it into the output register once that is free. A
// speed sample runs a multiply and a 16-bit divisor division twice on one
// shared divider that retires one quotient bit per cycle over a
// 32 + clog2(max(1000, SPEED_SCALE) + 1) bit dividend (42 at the default scale).
// One item is in work at a time; the next one is taken while a finished
// result still waits in the output register. Wheels at or above NUM_WHEELS
// are ignored. A divisor register written as zero acts as one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quadrature_count_and_speed_top import qcs_pkg::*; #(
  parameter int NUM_WHEELS  = QCS_NUM_WHEELS,
  parameter int SPEED_SCALE = QCS_SPEED_SCALE
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic               wheel_i,
  input  logic               a_edge_i,
  input  logic               b_edge_i,
  input  logic               a_level_i,
  input  logic               b_level_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               wheel_out_o,
  output logic signed [31:0] count_o,
  output logic signed [31:0] delta_o,
  output logic signed [31:0] pulses_per_sec_o,
  output logic signed [31:0] rev_rate_milli_o
);

  logic [CFG_W-1:0] period_q;
  logic [CFG_W-1:0] cpr_q;
  logic [CFG_W-1:0] period_eff;
  logic [CFG_W-1:0] cpr_eff;
  logic             wr_en;
  qcs_cmd_t         cmd;
  qcs_sts_t         sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
      cpr_q    <= CPR_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_PERIOD: period_q <= pwdata[CFG_W-1:0];
        REG_CPR:    cpr_q    <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PERIOD: prdata = 32'(period_q);
      REG_CPR:    prdata = 32'(cpr_q);
      default:    prdata = '0;
    endcase
  end

  // zero divisor acts as one
  assign period_eff = (period_q == '0) ? CFG_W'(1) : period_q;
  assign cpr_eff    = (cpr_q == '0) ? CFG_W'(1) : cpr_q;

  qcs_ctrl #(
    .NUM_WHEELS (NUM_WHEELS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .mode_i      (qcs_mode_e'(mode_i)),
    .wheel_i     (wheel_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  qcs_dp #(
    .NUM_WHEELS  (NUM_WHEELS),
    .SPEED_SCALE (SPEED_SCALE)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .wheel_i          (wheel_i),
    .a_edge_i         (a_edge_i),
    .b_edge_i         (b_edge_i),
    .a_level_i        (a_level_i),
    .b_level_i        (b_level_i),
    .period_i         (period_eff),
    .cpr_i            (cpr_eff),
    .wheel_out_o      (wheel_out_o),
    .count_o          (count_o),
    .delta_o          (delta_o),
    .pulses_per_sec_o (pulses_per_sec_o),
    .rev_rate_milli_o (rev_rate_milli_o)
  );

endmodule

>>> src/qcs_div.sv
// ----------------------------------------------------------------------------
// qcs_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qcs_div import qcs_pkg::*; #(
  parameter int DIVD_W = 42,
  parameter int DIVS_W = CFG_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [DIVS_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DIVD_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [DIVS_W-1:0] rem_q, rem_d;
  logic [DIVD_W-1:0] quo_q, quo_d;
  logic [DIVS_W-1:0] dvs_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIVS_W:0]   trial;
  logic              ge;

  assign trial = {rem_q, quo_q[DIVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CNT_W'(DIVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? DIVS_W'(trial - {1'b0, dvs_q}) : DIVS_W'(trial);
      quo_d = {quo_q[DIVD_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a run");

endmodule

>>> src/qcs_dp.sv
// ----------------------------------------------------------------------------
// qcs_dp
// Datapath: wheel counts, speed arithmetic and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qcs_dp import qcs_pkg::*; #(
  parameter int NUM_WHEELS  = QCS_NUM_WHEELS,
  parameter int SPEED_SCALE = QCS_SPEED_SCALE
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qcs_cmd_t          cmd_i,
  output qcs_sts_t          sts_o,
  input  logic              wheel_i,
  input  logic              a_edge_i,
  input  logic              b_edge_i,
  input  logic              a_level_i,
  input  logic              b_level_i,
  input  logic [CFG_W-1:0]  period_i,
  input  logic [CFG_W-1:0]  cpr_i,
  output logic              wheel_out_o,
  output logic signed [31:0] count_o,
  output logic signed [31:0] delta_o,
  output logic signed [31:0] pulses_per_sec_o,
  output logic signed [31:0] rev_rate_milli_o
);

  localparam int WIDX       = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;
  localparam int FACTOR_MAX = (SPEED_SCALE > MS_PER_SEC) ? SPEED_SCALE : MS_PER_SEC;
  localparam int PROD_W     = 32 + $clog2(FACTOR_MAX + 1);

  localparam logic [PROD_W-1:0] POS_LIM = PROD_W'(32'h7FFF_FFFF);
  localparam logic [PROD_W-1:0] NEG_LIM = PROD_W'(32'h8000_0000);

  logic [31:0]       pos_q [NUM_WHEELS];
  logic [31:0]       smp_q [NUM_WHEELS];
  logic [WIDX-1:0]   widx;
  logic [31:0]       pos_sel;
  logic [31:0]       step_a, step_b;
  logic [31:0]       pos_step;
  logic [31:0]       dlt;

  logic              wheel_q;
  logic [31:0]       cnt_q;
  logic [31:0]       delta_q;
  logic              neg_q;
  logic [31:0]       mag_q;
  logic [PROD_W-1:0] prod_q;
  logic [31:0]       pps_q;
  logic [31:0]       rev_q;

  logic              div_start;
  logic [CFG_W-1:0]  div_dvs;
  logic [PROD_W-1:0] quo;
  logic [31:0]       sat_m;
  logic [31:0]       sat_v;

  function automatic logic [31:0] sat_mag(input logic neg, input logic [PROD_W-1:0] q);
    logic [PROD_W-1:0] lim;
    lim = neg ? NEG_LIM : POS_LIM;
    if (q > lim) begin
      return lim[31:0];
    end
    return q[31:0];
  endfunction

  assign widx    = WIDX'(wheel_i);
  assign pos_sel = pos_q[widx];

  // a edge: up when b high; b edge: down when a high
  assign step_a   = a_edge_i ? (b_level_i ? 32'd1 : 32'hFFFF_FFFF) : 32'd0;
  assign step_b   = b_edge_i ? (a_level_i ? 32'hFFFF_FFFF : 32'd1) : 32'd0;
  assign pos_step = pos_sel + step_a + step_b;
  assign dlt      = pos_sel - smp_q[widx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        pos_q[i] <= '0;
        smp_q[i] <= '0;
      end
    end else if (cmd_i.clear_all) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        pos_q[i] <= '0;
        smp_q[i] <= '0;
      end
    end else begin
      if (cmd_i.edge_upd) begin
        pos_q[widx] <= pos_step;
      end
      if (cmd_i.cap_sample) begin
        smp_q[widx] <= pos_sel;
      end
    end
  end

  assign sat_m = sat_mag(neg_q, quo);
  assign sat_v = neg_q ? (~sat_m + 32'd1) : sat_m;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_read || cmd_i.cap_sample) begin
      wheel_q <= wheel_i;
      cnt_q   <= pos_sel;
    end
    if (cmd_i.cap_read) begin
      delta_q <= '0;
      pps_q   <= '0;
      rev_q   <= '0;
    end
    if (cmd_i.cap_sample) begin
      delta_q <= dlt;
      neg_q   <= dlt[31];
      mag_q   <= dlt[31] ? (~dlt + 32'd1) : dlt;
    end
    if (cmd_i.mul1) begin
      prod_q <= PROD_W'(mag_q) * PROD_W'(MS_PER_SEC);
    end
    if (cmd_i.sat1) begin
      mag_q <= sat_m;
      pps_q <= sat_v;
    end
    if (cmd_i.mul2) begin
      prod_q <= PROD_W'(mag_q) * PROD_W'(SPEED_SCALE);
    end
    if (cmd_i.sat2) begin
      rev_q <= sat_v;
    end
    if (cmd_i.push) begin
      wheel_out_o      <= wheel_q;
      count_o          <= cnt_q;
      delta_o          <= delta_q;
      pulses_per_sec_o <= pps_q;
      rev_rate_milli_o <= rev_q;
    end
  end

  assign div_start = cmd_i.ld1 || cmd_i.ld2;
  assign div_dvs   = cmd_i.ld1 ? period_i : cpr_i;

  qcs_div #(
    .DIVD_W (PROD_W),
    .DIVS_W (CFG_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (div_dvs),
    .done_o     (sts_o.div_done),
    .quo_o      (quo)
  );

endmodule

>>> src/qcs_ctrl.sv
// ----------------------------------------------------------------------------
// qcs_ctrl
// Controller: item intake, speed calculation sequence and output handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qcs_ctrl import qcs_pkg::*; #(
  parameter int NUM_WHEELS = QCS_NUM_WHEELS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  qcs_mode_e mode_i,
  input  logic      wheel_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output qcs_cmd_t  cmd_o,
  input  qcs_sts_t  sts_i
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_MUL1 = 10'b00_0000_0010,
    S_LD1  = 10'b00_0000_0100,
    S_DIV1 = 10'b00_0000_1000,
    S_SAT1 = 10'b00_0001_0000,
    S_MUL2 = 10'b00_0010_0000,
    S_LD2  = 10'b00_0100_0000,
    S_DIV2 = 10'b00_1000_0000,
    S_SAT2 = 10'b01_0000_0000,
    S_PUSH = 10'b10_0000_0000
  } qcs_state_e;

  qcs_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       wheel_ok;
  logic       out_free;

  assign wheel_ok = 32'(wheel_i) < 32'(NUM_WHEELS);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (mode_i)
            MODE_EDGE: begin
              cmd_o.edge_upd = wheel_ok;
            end
            MODE_CLEAR: begin
              cmd_o.clear_all = 1'b1;
            end
            MODE_SAMPLE: begin
              if (wheel_ok) begin
                cmd_o.cap_sample = 1'b1;
                state_d          = S_MUL1;
              end
            end
            MODE_READ: begin
              if (wheel_ok) begin
                cmd_o.cap_read = 1'b1;
                state_d        = S_PUSH;
              end
            end
            default: ;
          endcase
        end
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_LD1;
      end
      S_LD1: begin
        cmd_o.ld1 = 1'b1;
        state_d   = S_DIV1;
      end
      S_DIV1: begin
        if (sts_i.div_done) begin
          state_d = S_SAT1;
        end
      end
      S_SAT1: begin
        cmd_o.sat1 = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_LD2;
      end
      S_LD2: begin
        cmd_o.ld2 = 1'b1;
        state_d   = S_DIV2;
      end
      S_DIV2: begin
        if (sts_i.div_done) begin
          state_d = S_SAT2;
        end
      end
      S_SAT2: begin
        cmd_o.sat2 = 1'b1;
        state_d    = S_PUSH;
      end
      S_PUSH: begin
        // wait for the output register to free up
        if (out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

  a_valid_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_PUSH))
    else $error("result shown without a push");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_DIV1 || state_q == S_DIV2))
    else $error("divider done outside a divide state");

  a_push_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH && out_valid_q && out_stall_i) |=> state_q == S_PUSH)
    else $error("result pushed over a stalled item");

endmodule
